FILE: design/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared types and constants of the gradient pixel shader.
// ----------------------------------------------------------------------------
package gps_pkg;

	// default geometry of the block
	localparam int MAX_STOPS_DEF   = 8;
	localparam int INDEX_STEPS_DEF = 1024;
	localparam int COORD_BITS_DEF  = 12;

	// stop positions are given in units of 1/1023
	localparam int STOP_DEN = 1023;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register reset values
	localparam logic [15:0] START_X_RST    = 16'd50;
	localparam logic [15:0] START_Y_RST    = 16'd50;
	localparam logic [15:0] END_X_RST      = 16'd350;
	localparam logic [15:0] END_Y_RST      = 16'd250;
	localparam logic [3:0]  STOP_COUNT_RST = 4'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_X    = 3'd0,
		REG_START_Y    = 3'd1,
		REG_END_X      = 3'd2,
		REG_END_Y      = 3'd3,
		REG_RADIAL     = 3'd4,
		REG_STOP_COUNT = 3'd5
	} cfg_reg_t;

	// input item modes
	localparam logic MODE_SHADE = 1'b0;

	// class of a queued item
	typedef enum logic [1:0] {
		ITEM_SHADE,
		ITEM_STOP,
		ITEM_DROP
	} item_kind_t;

	// one queued item, front to back
	typedef struct packed {
		item_kind_t  kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [2:0]  index;
		logic [9:0]  pos;
		logic [23:0] color;
	} queue_item_t;

	// back end sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_CLASS,
		S_SCALE,
		S_DIV,
		S_SQRT,
		S_LOOK,
		S_FIRST,
		S_LAST,
		S_SCAN0,
		S_SCAN,
		S_LERP,
		S_LDIV,
		S_OUT
	} back_state_t;

	// what the shared divider is working on
	typedef enum logic [1:0] {
		DIV_LIN,
		DIV_RAD,
		DIV_LERP
	} div_kind_t;

endpackage

FILE: design/gradient_pixel_shader.sv
// ----------------------------------------------------------------------------
// gradient_pixel_shader
// Linear or radial multi-stop gradient color generator, one pixel per shade item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): mode 1 writes one stop table entry (an
// index not below MAX_STOPS is dropped) and gives no result; mode 0 shades
// pixel (pixel_x, pixel_y) and gives one pixel_color on out_valid/out_ready.
// Configuration channel (cfg_valid/cfg_ready) is always ready; write it only
// while no pixel is in flight.
// A two-entry queue separates the input side from the sequencer, so items are
// taken while the sequencer works. The sequencer handles one item at a time.
// A stop write is taken from the queue in the idle state. A pixel passes the
// multiply and class steps, then, unless its index clamps at either end, the
// scale and serial divide steps (radial adds a square root step), then the
// table lookup, blend and output steps; the blend reuses the shared divider.
// Reset empties the queue, clears the output and loads the register defaults;
// the stop table holds no reset value. A stalled output holds its transfer
// while the next pixel waits finished in the sequencer.
// ----------------------------------------------------------------------------
module gradient_pixel_shader #(
	parameter int MAX_STOPS   = gps_pkg::MAX_STOPS_DEF,
	parameter int INDEX_STEPS = gps_pkg::INDEX_STEPS_DEF,
	parameter int COORD_BITS  = gps_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [11:0]                     pixel_x,
	input  logic [11:0]                     pixel_y,
	input  logic [2:0]                      stop_index,
	input  logic [9:0]                      stop_position,
	input  logic [23:0]                     stop_color,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [23:0]                     pixel_color
);

	logic                 q_valid;
	logic                 q_ready;
	gps_pkg::queue_item_t q_item;

	// input classification and queue
	gps_front #(
		.MAX_STOPS (MAX_STOPS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.stop_index    (stop_index),
		.stop_position (stop_position),
		.stop_color    (stop_color),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_item        (q_item)
	);

	// sequencer, stop table and output register
	gps_back #(
		.MAX_STOPS   (MAX_STOPS),
		.INDEX_STEPS (INDEX_STEPS),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_item      (q_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_color (pixel_color)
	);

endmodule

FILE: design/gps_front.sv
// ----------------------------------------------------------------------------
// gps_front
// Input side: takes items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module gps_front #(
	parameter int MAX_STOPS = gps_pkg::MAX_STOPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  logic [11:0]          pixel_x,
	input  logic [11:0]          pixel_y,
	input  logic [2:0]           stop_index,
	input  logic [9:0]           stop_position,
	input  logic [23:0]          stop_color,
	output logic                 q_valid,
	input  logic                 q_ready,
	output gps_pkg::queue_item_t q_item
);

	gps_pkg::queue_item_t entry_q [2];
	gps_pkg::queue_item_t cls_item;
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;
	logic [6:0]           index_ext;

	// classify the incoming item
	always_comb begin
		index_ext      = 7'(stop_index);
		cls_item.x     = pixel_x;
		cls_item.y     = pixel_y;
		cls_item.index = stop_index;
		cls_item.pos   = stop_position;
		cls_item.color = stop_color;
		if (mode == gps_pkg::MODE_SHADE) begin
			cls_item.kind = gps_pkg::ITEM_SHADE;
		end else if (index_ext < 7'(MAX_STOPS)) begin
			cls_item.kind = gps_pkg::ITEM_STOP;
		end else begin
			cls_item.kind = gps_pkg::ITEM_DROP;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_item   = entry_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls_item;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/gps_back.sv
// ----------------------------------------------------------------------------
// gps_back
// Execution side: stop table, gradient index sequencer, color blend, output.
// ----------------------------------------------------------------------------
module gps_back #(
	parameter int MAX_STOPS   = gps_pkg::MAX_STOPS_DEF,
	parameter int INDEX_STEPS = gps_pkg::INDEX_STEPS_DEF,
	parameter int COORD_BITS  = gps_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  gps_pkg::queue_item_t            q_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gps_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [23:0]                     pixel_color
);

	localparam int B    = $clog2(INDEX_STEPS);
	localparam int QW   = 2 * B;
	localparam int TMAX = INDEX_STEPS - 1;
	localparam int TW   = B + 10;
	localparam int PW   = TW + 8;
	localparam int LW   = 34;
	localparam int DW   = LW + QW;
	localparam int QMAX = (QW > 8) ? QW : 8;
	localparam int DCW  = $clog2(QMAX + 1);
	localparam int AW   = $clog2(MAX_STOPS);
	localparam logic [11:0] CMASK = 12'((32'd1 << COORD_BITS) - 32'd1);

	// configuration registers
	logic [15:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic        radial_q;
	logic [3:0]  stop_count_q;

	gps_pkg::back_state_t state_q, state_d;

	// datapath registers
	logic [1:0]         mcnt_q;
	logic [11:0]        x_q, y_q;
	logic [LW-1:0]      len2_q;
	logic signed [34:0] acc_q;
	logic [DW-1:0]      scale_q;
	logic               scnt_q;
	logic [B-1:0]       idx_q, sqk_q, sqbit_q;
	logic [TW-1:0]      t_q, num_q, range_q;
	logic [33:0]        prev_q;
	logic [AW-1:0]      i_q;
	logic [23:0]        c1_q, c2_q, col_q;
	logic [1:0]         ch_q;
	logic [LW-1:0]      div_rem_q, div_dvs_q;
	logic [QMAX-1:0]    div_dvd_q, div_quo_q;
	logic [DCW-1:0]     div_cnt_q;
	logic               out_valid_q;
	logic [23:0]        out_col_q;

	// stop table
	logic [33:0]   stop_mem [MAX_STOPS];
	logic [33:0]   mem_rd_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic          mem_we;

	// combinational helpers
	logic signed [16:0] dx, dy, px, py, mul_a, mul_b;
	logic signed [33:0] mul_p;
	logic [LW-1:0]      len2_eff, d2;
	logic               lin_zero, lin_full, rad_full;
	logic [DW-1:0]      scale_mul;
	logic [LW:0]        div_r2;
	logic               div_ge;
	logic [LW-1:0]      div_rem_n;
	logic [QMAX-1:0]    div_quo_n;
	logic               div_last;
	logic               div_start;
	gps_pkg::div_kind_t div_kind;
	logic [DW-1:0]      div_src;
	logic [LW-1:0]      div_dvs_in;
	logic [B-1:0]       sq_trial;
	logic [QW-1:0]      sq_sq;
	logic               sq_ok;
	logic [9:0]         rd_pos, prev_pos;
	logic [TW-1:0]      pos_scaled, prev_scaled;
	logic               first_hit, last_hit, pair_hit, scan_end;
	logic [6:0]         sc_ext, n_eff;
	logic [AW-1:0]      n_last;
	logic [7:0]         lerp_a, lerp_b, lerp_diff, lerp_res;
	logic [PW-1:0]      lerp_prod;
	logic               out_free;

	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign pixel_color = out_col_q;
	assign out_free    = !out_valid_q || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q    <= gps_pkg::START_X_RST;
			start_y_q    <= gps_pkg::START_Y_RST;
			end_x_q      <= gps_pkg::END_X_RST;
			end_y_q      <= gps_pkg::END_Y_RST;
			radial_q     <= 1'b0;
			stop_count_q <= gps_pkg::STOP_COUNT_RST;
		end else if (cfg_valid) begin
			case (gps_pkg::cfg_reg_t'(cfg_index))
				gps_pkg::REG_START_X:    start_x_q    <= cfg_data;
				gps_pkg::REG_START_Y:    start_y_q    <= cfg_data;
				gps_pkg::REG_END_X:      end_x_q      <= cfg_data;
				gps_pkg::REG_END_Y:      end_y_q      <= cfg_data;
				gps_pkg::REG_RADIAL:     radial_q     <= cfg_data[0];
				gps_pkg::REG_STOP_COUNT: stop_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// axis and pixel offsets, one shared multiplier
	always_comb begin
		dx = $signed({end_x_q[15], end_x_q}) - $signed({start_x_q[15], start_x_q});
		dy = $signed({end_y_q[15], end_y_q}) - $signed({start_y_q[15], start_y_q});
		px = $signed({5'b0, x_q & CMASK}) - $signed({start_x_q[15], start_x_q});
		py = $signed({5'b0, y_q & CMASK}) - $signed({start_y_q[15], start_y_q});
		case (mcnt_q)
			2'd0: begin
				mul_a = dx;
				mul_b = dx;
			end
			2'd1: begin
				mul_a = dy;
				mul_b = dy;
			end
			2'd2: begin
				mul_a = px;
				mul_b = radial_q ? px : dx;
			end
			default: begin
				mul_a = py;
				mul_b = radial_q ? py : dy;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// classification of the projection or distance
	assign len2_eff  = (len2_q == '0) ? LW'(1) : len2_q;
	assign d2        = acc_q[LW-1:0];
	assign lin_zero  = (acc_q <= 35'sd0);
	assign lin_full  = (acc_q >= $signed({1'b0, len2_eff}));
	assign rad_full  = (d2 >= len2_eff);
	assign scale_mul = scale_q * DW'(TMAX);

	// restoring divider step
	always_comb begin
		div_r2    = {div_rem_q, div_dvd_q[QMAX-1]};
		div_ge    = (div_r2 >= {1'b0, div_dvs_q});
		div_rem_n = div_ge ? LW'(div_r2 - {1'b0, div_dvs_q}) : div_r2[LW-1:0];
		div_quo_n = {div_quo_q[QMAX-2:0], div_ge};
		div_last  = (div_cnt_q == DCW'(1));
	end

	// square root trial bit
	assign sq_trial = sqk_q | sqbit_q;
	assign sq_sq    = QW'(sq_trial) * QW'(sq_trial);
	assign sq_ok    = (sq_sq <= div_quo_q[QW-1:0]);

	// stop table compares
	always_comb begin
		rd_pos      = mem_rd_q[33:24];
		prev_pos    = prev_q[33:24];
		pos_scaled  = TW'(rd_pos) * TW'(TMAX);
		prev_scaled = TW'(prev_pos) * TW'(TMAX);
		first_hit   = (t_q <= pos_scaled);
		last_hit    = (t_q >= pos_scaled);
		pair_hit    = (t_q >= prev_scaled) && (t_q <= pos_scaled);
		sc_ext      = 7'(stop_count_q);
		if (sc_ext < 7'd2) begin
			n_eff = 7'd2;
		end else if (sc_ext > 7'(MAX_STOPS)) begin
			n_eff = 7'(MAX_STOPS);
		end else begin
			n_eff = sc_ext;
		end
		n_last   = AW'(n_eff - 7'd1);
		scan_end = (i_q == n_last);
	end

	// channel blend operands
	always_comb begin
		case (ch_q)
			2'd2: begin
				lerp_a = c1_q[23:16];
				lerp_b = c2_q[23:16];
			end
			2'd1: begin
				lerp_a = c1_q[15:8];
				lerp_b = c2_q[15:8];
			end
			default: begin
				lerp_a = c1_q[7:0];
				lerp_b = c2_q[7:0];
			end
		endcase
		lerp_diff = (lerp_b >= lerp_a) ? (lerp_b - lerp_a) : (lerp_a - lerp_b);
		lerp_prod = PW'(lerp_diff) * PW'(num_q);
		lerp_res  = (lerp_b >= lerp_a) ? (lerp_a + div_quo_n[7:0]) :
			(lerp_a - div_quo_n[7:0]);
	end

	// next state and control
	always_comb begin
		state_d    = state_q;
		q_ready    = 1'b0;
		mem_we     = 1'b0;
		rd_addr    = '0;
		div_start  = 1'b0;
		div_kind   = gps_pkg::DIV_LIN;
		div_src    = scale_mul;
		div_dvs_in = len2_eff;
		wr_addr    = AW'(7'(q_item.index));
		case (state_q)
			gps_pkg::S_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					if (q_item.kind == gps_pkg::ITEM_SHADE) begin
						state_d = gps_pkg::S_MUL;
					end else if (q_item.kind == gps_pkg::ITEM_STOP) begin
						mem_we = 1'b1;
					end
				end
			end
			gps_pkg::S_MUL: begin
				if (mcnt_q == 2'd3) begin
					state_d = gps_pkg::S_CLASS;
				end
			end
			gps_pkg::S_CLASS: begin
				if (radial_q) begin
					state_d = rad_full ? gps_pkg::S_LOOK : gps_pkg::S_SCALE;
				end else begin
					state_d = (lin_zero || lin_full) ? gps_pkg::S_LOOK : gps_pkg::S_SCALE;
				end
			end
			gps_pkg::S_SCALE: begin
				if (!scnt_q) begin
					div_start = 1'b1;
					div_kind  = radial_q ? gps_pkg::DIV_RAD : gps_pkg::DIV_LIN;
					state_d   = gps_pkg::S_DIV;
				end
			end
			gps_pkg::S_DIV: begin
				if (div_last) begin
					state_d = radial_q ? gps_pkg::S_SQRT : gps_pkg::S_LOOK;
				end
			end
			gps_pkg::S_SQRT: begin
				if (sqbit_q[0]) begin
					state_d = gps_pkg::S_LOOK;
				end
			end
			gps_pkg::S_LOOK: begin
				state_d = gps_pkg::S_FIRST;
			end
			gps_pkg::S_FIRST: begin
				if (first_hit) begin
					state_d = gps_pkg::S_OUT;
				end else begin
					rd_addr = n_last;
					state_d = gps_pkg::S_LAST;
				end
			end
			gps_pkg::S_LAST: begin
				state_d = last_hit ? gps_pkg::S_OUT : gps_pkg::S_SCAN0;
			end
			gps_pkg::S_SCAN0: begin
				rd_addr = AW'(1);
				state_d = gps_pkg::S_SCAN;
			end
			gps_pkg::S_SCAN: begin
				if (pair_hit) begin
					state_d = (pos_scaled == prev_scaled) ? gps_pkg::S_OUT : gps_pkg::S_LERP;
				end else if (scan_end) begin
					state_d = gps_pkg::S_OUT;
				end else begin
					rd_addr = i_q + AW'(1);
				end
			end
			gps_pkg::S_LERP: begin
				div_start  = 1'b1;
				div_kind   = gps_pkg::DIV_LERP;
				div_src    = DW'(lerp_prod);
				div_dvs_in = LW'(range_q);
				state_d    = gps_pkg::S_LDIV;
			end
			gps_pkg::S_LDIV: begin
				if (div_last) begin
					state_d = (ch_q == 2'd0) ? gps_pkg::S_OUT : gps_pkg::S_LERP;
				end
			end
			gps_pkg::S_OUT: begin
				if (out_free) begin
					state_d = gps_pkg::S_IDLE;
				end
			end
			default: state_d = gps_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gps_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stop table write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stop_mem[wr_addr] <= {q_item.pos, q_item.color};
		end
		mem_rd_q <= stop_mem[rd_addr];
	end

	// shared divider
	always_ff @(posedge clk) begin
		if (div_start) begin
			div_dvs_q <= div_dvs_in;
			div_quo_q <= '0;
			case (div_kind)
				gps_pkg::DIV_RAD: begin
					div_rem_q <= LW'(div_src >> QW);
					div_dvd_q <= QMAX'(QMAX'(div_src) << (QMAX - QW));
					div_cnt_q <= DCW'(QW);
				end
				gps_pkg::DIV_LERP: begin
					div_rem_q <= LW'(div_src >> 8);
					div_dvd_q <= QMAX'(QMAX'(div_src) << (QMAX - 8));
					div_cnt_q <= DCW'(8);
				end
				default: begin
					div_rem_q <= LW'(div_src >> B);
					div_dvd_q <= QMAX'(QMAX'(div_src) << (QMAX - B));
					div_cnt_q <= DCW'(B);
				end
			endcase
		end else if (state_q == gps_pkg::S_DIV || state_q == gps_pkg::S_LDIV) begin
			div_rem_q <= div_rem_n;
			div_dvd_q <= div_dvd_q << 1;
			div_quo_q <= div_quo_n;
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gps_pkg::S_IDLE: begin
				x_q    <= q_item.x;
				y_q    <= q_item.y;
				mcnt_q <= 2'd0;
			end
			gps_pkg::S_MUL: begin
				mcnt_q <= mcnt_q + 2'd1;
				case (mcnt_q)
					2'd0: len2_q <= LW'(mul_p);
					2'd1: len2_q <= len2_q + LW'(mul_p);
					2'd2: acc_q  <= {mul_p[33], mul_p};
					default: acc_q <= acc_q + {mul_p[33], mul_p};
				endcase
			end
			gps_pkg::S_CLASS: begin
				scale_q <= DW'(d2);
				scnt_q  <= radial_q;
				if (radial_q || !lin_zero) begin
					idx_q <= B'(TMAX);
				end else begin
					idx_q <= '0;
				end
			end
			gps_pkg::S_SCALE: begin
				scale_q <= scale_mul;
				scnt_q  <= 1'b0;
			end
			gps_pkg::S_DIV: begin
				if (div_last) begin
					idx_q   <= div_quo_n[B-1:0];
					sqk_q   <= '0;
					sqbit_q <= B'(1) << (B - 1);
				end
			end
			gps_pkg::S_SQRT: begin
				if (sq_ok) begin
					sqk_q <= sq_trial;
				end
				sqbit_q <= sqbit_q >> 1;
				if (sqbit_q[0]) begin
					idx_q <= sq_ok ? sq_trial : sqk_q;
				end
			end
			gps_pkg::S_LOOK: begin
				t_q <= TW'(idx_q) * TW'(gps_pkg::STOP_DEN);
			end
			gps_pkg::S_FIRST: begin
				col_q <= mem_rd_q[23:0];
			end
			gps_pkg::S_LAST: begin
				col_q <= mem_rd_q[23:0];
			end
			gps_pkg::S_SCAN0: begin
				prev_q <= mem_rd_q;
				i_q    <= AW'(1);
			end
			gps_pkg::S_SCAN: begin
				prev_q  <= mem_rd_q;
				i_q     <= i_q + AW'(1);
				num_q   <= t_q - prev_scaled;
				range_q <= pos_scaled - prev_scaled;
				c1_q    <= prev_q[23:0];
				c2_q    <= mem_rd_q[23:0];
				ch_q    <= 2'd2;
				col_q   <= pair_hit ? prev_q[23:0] : 24'd0;
			end
			gps_pkg::S_LDIV: begin
				if (div_last) begin
					col_q <= {col_q[15:0], lerp_res};
					ch_q  <= ch_q - 2'd1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == gps_pkg::S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gps_pkg::S_OUT && out_free) begin
			out_col_q <= col_q;
		end
	end

endmodule

FILE: design/gps_checker.sv
// ----------------------------------------------------------------------------
// gps_checker
// Port-level checks of the gradient pixel shader, bound to the top level.
// ----------------------------------------------------------------------------
module gps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] pixel_color
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output transfer dropped while stalled");

	// a stalled result keeps its color
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pixel_color))
		else $error("pixel color changed while stalled");

	// register writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

	// reset empties the queue and the output register
	a_reset_state: assert property (@(posedge clk)
		!arst_n |-> in_ready && !out_valid)
		else $error("reset did not clear queue or output");

endmodule

bind gradient_pixel_shader gps_checker u_gps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.cfg_valid   (cfg_valid),
	.cfg_ready   (cfg_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.pixel_color (pixel_color)
);
